// ===== hdl/increase_run_window_checker_unit_macros.svh =====
// Assertion helpers for the run window checker.
`ifndef INCREASE_RUN_WINDOW_CHECKER_UNIT_MACROS_SVH
`define INCREASE_RUN_WINDOW_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IRWC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("irwc: assertion failed");

// Next-cycle implication, disabled during reset.
`define IRWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("irwc: assertion failed");

`endif

// ===== hdl/irwc_pkg.sv =====
`timescale 1ns / 1ps

package irwc_pkg;

	localparam int MAX_SPAN_DEF    = 15;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int PADDR_W         = 4;
	localparam int PDATA_W         = 32;
	localparam int INDEX_W         = 16;

	localparam logic signed [31:0] MIN_STEP_RST    = 32'sd66;
	localparam logic signed [31:0] MAX_STEP_RST    = 32'sd655360;
	localparam logic [3:0]         LEFT_MARGIN_RST = 4'd0;
	localparam logic [3:0]         RIGHT_SPAN_RST  = 4'd1;

	typedef enum logic [1:0] {
		VERDICT_HOLD = 2'd0,
		VERDICT_FAIL = 2'd1,
		VERDICT_NA   = 2'd2
	} verdict_t;

	typedef enum logic [1:0] {
		REG_MIN_STEP    = 2'd0,
		REG_MAX_STEP    = 2'd1,
		REG_LEFT_MARGIN = 2'd2,
		REG_RIGHT_SPAN  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] min_step;
		logic signed [31:0] max_step;
		logic [3:0]         left_margin;
		logic [3:0]         right_span;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic advance;
	} step_ctl_t;

endpackage

// ===== hdl/irwc_if.sv =====
`timescale 1ns / 1ps

interface irwc_in_if #(parameter int SAMPLE_BITS = irwc_pkg::SAMPLE_BITS_DEF);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   series_end;

	modport source (output valid, sample, series_end, input ready);
	modport sink (input valid, sample, series_end, output ready);
endinterface

interface irwc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [15:0] point_index;
	logic        last_of_run;

	modport source (output valid, verdict, point_index, last_of_run, input ready);
	modport sink (input valid, verdict, point_index, last_of_run, output ready);
endinterface

// ===== hdl/irwc_ram.sv =====
`timescale 1ns / 1ps

module irwc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/irwc_cfg.sv =====
`timescale 1ns / 1ps

module irwc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [irwc_pkg::PADDR_W-1:0]  paddr,
	input  logic [irwc_pkg::PDATA_W-1:0]  pwdata,
	output logic [irwc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output irwc_pkg::cfg_t                cfg
);

	import irwc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_step    <= MIN_STEP_RST;
			cfg_q.max_step    <= MAX_STEP_RST;
			cfg_q.left_margin <= LEFT_MARGIN_RST;
			cfg_q.right_span  <= RIGHT_SPAN_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_MIN_STEP:    cfg_q.min_step    <= pwdata;
				REG_MAX_STEP:    cfg_q.max_step    <= pwdata;
				REG_LEFT_MARGIN: cfg_q.left_margin <= pwdata[3:0];
				REG_RIGHT_SPAN:  cfg_q.right_span  <= pwdata[3:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MIN_STEP:    prdata = cfg_q.min_step;
			REG_MAX_STEP:    prdata = cfg_q.max_step;
			REG_LEFT_MARGIN: prdata = {28'd0, cfg_q.left_margin};
			REG_RIGHT_SPAN:  prdata = {28'd0, cfg_q.right_span};
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/irwc_step.sv =====
`timescale 1ns / 1ps

module irwc_step #(
	parameter int SAMPLE_BITS = irwc_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_SPAN    = irwc_pkg::MAX_SPAN_DEF
) (
	input  logic                   clk,
	input  irwc_pkg::step_ctl_t    ctl,
	input  irwc_pkg::cfg_t         cfg,
	input  logic [SAMPLE_BITS-1:0] rdata,
	output logic                   fail
);

	import irwc_pkg::*;

	localparam int JW = $clog2(MAX_SPAN + 1);
	localparam int TW = 32 + JW;
	localparam int DW = SAMPLE_BITS + 1;
	localparam int CW = (DW > TW) ? DW : TW;

	logic [SAMPLE_BITS-1:0] base_q;
	logic signed [CW-1:0]   lo_acc_q;
	logic signed [CW-1:0]   hi_acc_q;
	logic signed [CW-1:0]   x_ext;
	logic signed [CW-1:0]   b_ext;
	logic signed [CW-1:0]   lo_ext;
	logic signed [CW-1:0]   hi_ext;
	logic signed [CW-1:0]   diff;

	assign x_ext  = {{(CW-SAMPLE_BITS){rdata[SAMPLE_BITS-1]}}, rdata};
	assign b_ext  = {{(CW-SAMPLE_BITS){base_q[SAMPLE_BITS-1]}}, base_q};
	assign lo_ext = {{(CW-32){cfg.min_step[31]}}, cfg.min_step};
	assign hi_ext = {{(CW-32){cfg.max_step[31]}}, cfg.max_step};
	assign diff   = x_ext - b_ext;
	assign fail   = (diff < lo_acc_q) || (diff > hi_acc_q);

	// thresholds grow by one step per follower: acc = j * step
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			base_q   <= rdata;
			lo_acc_q <= lo_ext;
			hi_acc_q <= hi_ext;
		end else if (ctl.advance) begin
			lo_acc_q <= lo_acc_q + lo_ext;
			hi_acc_q <= hi_acc_q + hi_ext;
		end
	end

endmodule

// ===== hdl/increase_run_window_checker_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// samples   in   valid/ready        sample, series_end
// results   out  valid/ready        verdict, point_index, last_of_run
// apb       in   psel/penable/pwrite paddr, pwdata -> prdata, pready=1
// Each sample is written into the window from S_IDLE; a judged point compares one
// follower per cycle through the shared step unit and window RAM port (a failing
// compare ends the point early); points flushed, below the margin or judged with
// a zero span skip the compares and go straight to S_EMIT.
// Reset (arst_n low) empties the window and zeroes the point index.
// A result waits in the output register; the sequencer stalls only when a
// second result is due before the first transaction is taken.

module increase_run_window_checker_unit #(
	parameter int MAX_SPAN    = irwc_pkg::MAX_SPAN_DEF,
	parameter int SAMPLE_BITS = irwc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [irwc_pkg::PADDR_W-1:0] paddr,
	input  logic [irwc_pkg::PDATA_W-1:0] pwdata,
	output logic [irwc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	irwc_in_if.sink                      samples,
	irwc_out_if.source                   results
);

	import irwc_pkg::*;

	localparam int DEPTH = MAX_SPAN + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = $clog2(MAX_SPAN + 2);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_BASE,
		S_STEP,
		S_EMIT
	} state_t;

	state_t                 state_q;
	logic [AW-1:0]          head_q;
	logic [FW-1:0]          fill_q;
	logic [INDEX_W-1:0]     point_q;
	logic                   end_q;
	logic [AW-1:0]          j_q;
	verdict_t               verdict_q;
	logic                   out_valid_q;
	verdict_t               out_verdict_q;
	logic [INDEX_W-1:0]     out_index_q;
	logic                   out_last_q;

	cfg_t                   cfg;
	step_ctl_t              step_ctl;
	logic                   step_fail;
	logic [AW-1:0]          span;
	logic [AW-1:0]          fill_w;
	logic [AW-1:0]          rd_off;
	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          wr_addr;
	logic                   ram_we;
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic [FW-1:0]          remaining;
	logic                   last_res;
	logic                   emit_go;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	irwc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	irwc_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (samples.sample),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	irwc_step #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_SPAN    (MAX_SPAN)
	) u_step (
		.clk   (clk),
		.ctl   (step_ctl),
		.cfg   (cfg),
		.rdata (ram_rdata),
		.fail  (step_fail)
	);

	always_comb begin
		if (int'(cfg.right_span) > MAX_SPAN) begin
			span = AW'(MAX_SPAN);
		end else begin
			span = AW'(cfg.right_span);
		end
		if (fill_q > FW'(MAX_SPAN)) begin
			fill_w = AW'(MAX_SPAN);
		end else begin
			fill_w = AW'(fill_q);
		end
	end

	always_comb begin
		ram_we   = 1'b0;
		rd_off   = '0;
		step_ctl = '0;
		unique case (state_q)
			S_IDLE: ram_we = samples.valid;
			S_BASE: begin
				step_ctl.load = 1'b1;
				rd_off        = AW'(1);
			end
			S_STEP: begin
				if (!step_fail && j_q != span) begin
					step_ctl.advance = 1'b1;
					rd_off           = j_q + AW'(1);
				end
			end
			default: ;
		endcase
	end

	assign rd_addr   = wrap_add(head_q, rd_off);
	assign wr_addr   = wrap_add(head_q, fill_w);
	assign remaining = fill_q - FW'(1);
	assign last_res  = !(remaining > FW'(span)) && !(end_q && remaining != '0);
	assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= '0;
			fill_q        <= '0;
			point_q       <= '0;
			end_q         <= 1'b0;
			j_q           <= '0;
			verdict_q     <= VERDICT_HOLD;
			out_valid_q   <= 1'b0;
			out_verdict_q <= VERDICT_HOLD;
			out_index_q   <= '0;
			out_last_q    <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (samples.valid) begin
						fill_q  <= FW'(fill_w) + FW'(1);
						end_q   <= samples.series_end;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (fill_q > FW'(span)) begin
						if (point_q < INDEX_W'(cfg.left_margin)) begin
							verdict_q <= VERDICT_NA;
							state_q   <= S_EMIT;
						end else if (span == '0) begin
							verdict_q <= VERDICT_HOLD;
							state_q   <= S_EMIT;
						end else begin
							state_q <= S_BASE;
						end
					end else if (end_q && fill_q != '0) begin
						verdict_q <= VERDICT_NA;
						state_q   <= S_EMIT;
					end else begin
						if (end_q) begin
							fill_q  <= '0;
							point_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_BASE: begin
					j_q     <= AW'(1);
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (step_fail) begin
						verdict_q <= VERDICT_FAIL;
						state_q   <= S_EMIT;
					end else if (j_q == span) begin
						verdict_q <= VERDICT_HOLD;
						state_q   <= S_EMIT;
					end else begin
						j_q <= j_q + AW'(1);
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						out_verdict_q <= verdict_q;
						out_index_q   <= point_q;
						out_last_q    <= last_res;
						head_q        <= wrap_add(head_q, AW'(1));
						fill_q        <= remaining;
						point_q       <= point_q + INDEX_W'(1);
						state_q       <= S_CHECK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign samples.ready       = (state_q == S_IDLE);
	assign results.valid       = out_valid_q;
	assign results.verdict     = out_verdict_q;
	assign results.point_index = out_index_q;
	assign results.last_of_run = out_last_q;

endmodule

// ===== hdl/irwc_checker.sv =====
`timescale 1ns / 1ps
`include "increase_run_window_checker_unit_macros.svh"

module irwc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_verdict,
	input logic [15:0] out_index,
	input logic        out_last
);

	// sequencer is busy in the cycle after every input transaction
	`IRWC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// while idle, any pending result must close its run
	`IRWC_ASSERT_IMPLY(a_idle_pending_is_last, clk, arst_n, in_ready && out_valid, out_last)

	`IRWC_ASSERT_IMPLY(a_verdict_code, clk, arst_n, out_valid, out_verdict != 2'd3)

	`IRWC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_verdict) && $stable(out_index) && $stable(out_last))

endmodule

bind increase_run_window_checker_unit irwc_checker u_irwc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_verdict (results.verdict),
	.out_index   (results.point_index),
	.out_last    (results.last_of_run)
);

// ===== verif/increase_run_window_checker_unit_tb.sv =====
`timescale 1ns / 1ps

module increase_run_window_checker_unit_tb;
	import irwc_pkg::*;

	localparam int MAX_SPAN      = MAX_SPAN_DEF;
	localparam int RANDOM_ITEMS  = 360;
	localparam int PHASES        = 10;
	localparam int NO_IDLE_ITEMS = 40;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int CYCLE_LIMIT   = 3000000;
	localparam int STALL_CYCLES  = 300;

	typedef struct {
		verdict_t    verdict;
		logic [15:0] point;
		logic        last;
	} verdict_rec_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	irwc_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) sample_ch ();
	irwc_out_if result_ch ();

	increase_run_window_checker_unit #(
		.MAX_SPAN   (MAX_SPAN),
		.SAMPLE_BITS(SAMPLE_BITS_DEF)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.samples(sample_ch),
		.results(result_ch)
	);

	verdict_rec_t pending_verdicts[$];
	cfg_t         cfg_shadow;
	longint       win_vals[MAX_SPAN + 1];
	int           win_fill;
	logic [15:0]  next_pt;
	int           bad_count;
	bit           idle_en;
	int           stall_req;
	int           cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: random ready, plus long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if (stall_req > 0) begin
				stall_left = stall_req - 1;
				stall_req = 0;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= !(idle_en && $urandom_range(0, 99) < 15);
			end
		end
	end

	function automatic verdict_t rate_point(int span);
		longint lo;
		longint hi;
		longint rise;
		lo = longint'($signed(cfg_shadow.min_step));
		hi = longint'($signed(cfg_shadow.max_step));
		if (next_pt < 16'(cfg_shadow.left_margin))
			return VERDICT_NA;
		for (int j = 1; j <= span; j++) begin
			rise = win_vals[j] - win_vals[0];
			if (rise < lo * j || rise > hi * j)
				return VERDICT_FAIL;
		end
		return VERDICT_HOLD;
	endfunction

	function automatic void predict_verdicts(logic [31:0] value, logic series_end);
		verdict_rec_t rec;
		bit held;
		int span;
		span = int'(cfg_shadow.right_span);
		if (span > MAX_SPAN)
			span = MAX_SPAN;
		held = 1'b0;
		win_vals[win_fill] = longint'($signed(value));
		win_fill++;
		while (win_fill > span) begin
			if (held)
				pending_verdicts.push_back(rec);
			rec.verdict = rate_point(span);
			rec.point = next_pt;
			rec.last = 1'b0;
			held = 1'b1;
			next_pt++;
			for (int i = 0; i < win_fill - 1; i++)
				win_vals[i] = win_vals[i + 1];
			win_fill--;
		end
		if (series_end) begin
			while (win_fill > 0) begin
				if (held)
					pending_verdicts.push_back(rec);
				rec.verdict = VERDICT_NA;
				rec.point = next_pt;
				rec.last = 1'b0;
				held = 1'b1;
				next_pt++;
				win_fill--;
			end
			next_pt = '0;
		end
		if (held) begin
			rec.last = 1'b1;
			pending_verdicts.push_back(rec);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && sample_ch.valid && sample_ch.ready)
			predict_verdicts(sample_ch.sample, sample_ch.series_end);
	end

	always @(posedge clk) begin
		verdict_rec_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("unexpected result: verdict %0d point %0d last %0b",
						result_ch.verdict, result_ch.point_index, result_ch.last_of_run);
			end else begin
				want = pending_verdicts.pop_front();
				if (result_ch.verdict !== want.verdict ||
						result_ch.point_index !== want.point ||
						result_ch.last_of_run !== want.last) begin
					bad_count++;
					if (bad_count <= 10)
						$display("result mismatch: exp verdict %0d point %0d last %0b,",
							want.verdict, want.point, want.last,
							" got verdict %0d point %0d last %0b",
							result_ch.verdict, result_ch.point_index,
							result_ch.last_of_run);
				end
			end
		end
	end

	task automatic send_sample(input logic [31:0] value, input logic series_end);
		while (idle_en && $urandom_range(0, 99) < 15) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= value;
		sample_ch.series_end <= series_end;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
	endtask

	task automatic drain_results(input int settle);
		int waited;
		sample_ch.valid <= 1'b0;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT);
		repeat (settle) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MIN_STEP:    cfg_shadow.min_step = value;
			REG_MAX_STEP:    cfg_shadow.max_step = value;
			REG_LEFT_MARGIN: cfg_shadow.left_margin = value[3:0];
			REG_RIGHT_SPAN:  cfg_shadow.right_span = value[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] lo, input logic [31:0] hi,
			input logic [3:0] margin, input logic [3:0] span);
		cfg_write(REG_MIN_STEP, lo);
		cfg_write(REG_MAX_STEP, hi);
		cfg_write(REG_LEFT_MARGIN, {28'd0, margin});
		cfg_write(REG_RIGHT_SPAN, {28'd0, span});
	endtask

	task automatic check_reset_defaults();
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'h0001_0000, 1'b0);
		send_sample(32'h7FFF_FFFF, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b1);
		drain_results(SETTLE_CYCLES);
	endtask

	task automatic check_zero_span();
		set_config(32'h0, 32'h0, 4'd2, 4'd0);
		send_sample(32'd5, 1'b0);
		send_sample(32'd6, 1'b0);
		send_sample(32'd7, 1'b1);
		drain_results(SETTLE_CYCLES);
	endtask

	task automatic check_span_changes();
		set_config(32'h0001_0000, 32'h0002_0000, 4'd0, 4'd3);
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'h0001_8000, 1'b0);
		send_sample(32'h0003_0000, 1'b0);
		send_sample(32'h0004_8000, 1'b0);
		drain_results(SETTLE_CYCLES);
		// span lowered mid series: one sample completes several points
		cfg_write(REG_RIGHT_SPAN, 32'd1);
		send_sample(32'h0006_0000, 1'b0);
		drain_results(SETTLE_CYCLES);
		cfg_write(REG_RIGHT_SPAN, 32'd15);
		send_sample(32'h0007_0000, 1'b0);
		send_sample(32'h0008_0000, 1'b1);
		drain_results(SETTLE_CYCLES);
	endtask

	task automatic check_empty_range();
		set_config(32'h7FFF_FFFF, 32'h8000_0000, 4'd0, 4'd2);
		send_sample(32'd0, 1'b0);
		send_sample(32'd1, 1'b0);
		send_sample(32'd2, 1'b0);
		send_sample(32'd3, 1'b1);
		drain_results(SETTLE_CYCLES);
	endtask

	task automatic check_flush_below_margin();
		set_config(32'h0000_0042, 32'h000A_0000, 4'd15, 4'd15);
		send_sample(32'h0001_0000, 1'b0);
		send_sample(32'h0002_0000, 1'b0);
		send_sample(32'h0003_0000, 1'b1);
		drain_results(SETTLE_CYCLES);
		cfg_write(REG_RIGHT_SPAN, 32'd1);
		send_sample(32'h1234_5678, 1'b1);
		drain_results(SETTLE_CYCLES);
	endtask

	// runs with no idling on either side
	task automatic check_no_idle_run();
		logic [31:0] value;
		idle_en = 1'b0;
		set_config(32'h0000_0000, 32'h0004_0000, 4'd3, 4'd2);
		for (int i = 0; i < NO_IDLE_ITEMS; i++) begin
			value = ($urandom_range(0, 99) < 10) ? $urandom : 32'(i * 32'h0001_8000);
			send_sample(value, i == NO_IDLE_ITEMS - 1);
		end
		drain_results(SETTLE_CYCLES);
		idle_en = 1'b1;
	endtask

	task automatic check_output_stall();
		set_config(32'h0000_0000, 32'h0001_0000, 4'd1, 4'd0);
		stall_req = STALL_CYCLES;
		for (int i = 0; i < 24; i++)
			send_sample(32'(i * 1000), i == 23);
		drain_results(SETTLE_CYCLES);
	endtask

	task automatic check_paced_sender();
		set_config(32'h0000_0000, 32'h0002_0000, 4'd0, 4'd2);
		for (int i = 0; i < 12; i++) begin
			send_sample(32'(i * 32'h0001_0000), i == 11);
			drain_results(0);
		end
		drain_results(SETTLE_CYCLES);
	endtask

	task automatic check_random_series();
		longint lo;
		longint hi;
		longint rise;
		logic [31:0] cur;
		logic [3:0] margin;
		logic [3:0] span;
		int phase_items;
		int len;
		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					lo = longint'($urandom_range(0, 6 * 65536)) - 2 * 65536;
					hi = lo + longint'($urandom_range(0, 4 * 65536));
				end
				6: begin
					lo = -64'sd2147483648;
					hi = 64'sd2147483647;
				end
				7: begin
					hi = longint'($urandom_range(0, 4 * 65536)) - 2 * 65536;
					lo = hi + longint'($urandom_range(1, 65536));
				end
				default: begin
					lo = longint'($signed($urandom));
					hi = longint'($signed($urandom));
				end
			endcase
			margin = 4'($urandom_range(0, 15));
			span = 4'($urandom_range(0, 15));
			if (p == 0) begin
				margin = 4'd15;
				span = 4'd15;
			end else if (p == 1) begin
				margin = 4'd0;
				span = 4'd0;
			end
			set_config(32'(lo), 32'(hi), margin, span);
			phase_items = 0;
			while (phase_items < RANDOM_ITEMS / PHASES) begin
				len = $urandom_range(1, 2 * int'(span) + 10);
				cur = ($urandom_range(0, 3) == 0) ? $urandom :
					32'(longint'($urandom_range(0, 200 * 65536)) - 100 * 65536);
				for (int i = 0; i < len && phase_items < RANDOM_ITEMS / PHASES; i++) begin
					if ($urandom_range(0, 99) < 15) begin
						cur = $urandom;
					end else if (i > 0) begin
						rise = (hi >= lo) ?
							lo + longint'($urandom_range(0, 32'(hi - lo))) : lo;
						cur = 32'(longint'($signed(cur)) + rise);
					end
					send_sample(cur, i == len - 1);
					phase_items++;
				end
			end
			drain_results(SETTLE_CYCLES);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.sample <= '0;
		sample_ch.series_end <= 1'b0;
		cfg_shadow.min_step = MIN_STEP_RST;
		cfg_shadow.max_step = MAX_STEP_RST;
		cfg_shadow.left_margin = LEFT_MARGIN_RST;
		cfg_shadow.right_span = RIGHT_SPAN_RST;
		foreach (win_vals[i])
			win_vals[i] = 0;
		win_fill = 0;
		next_pt = '0;
		bad_count = 0;
		idle_en = 1'b1;
		stall_req = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_reset_defaults();
		check_zero_span();
		check_span_changes();
		check_empty_range();
		check_flush_below_margin();
		check_output_stall();
		check_paced_sender();
		check_random_series();
		check_no_idle_run();

		drain_results(SETTLE_CYCLES);
		bad_count += pending_verdicts.size();
		if (bad_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/irwc_pkg.sv
hdl/irwc_if.sv
hdl/irwc_ram.sv
hdl/irwc_cfg.sv
hdl/irwc_step.sv
hdl/increase_run_window_checker_unit.sv
hdl/irwc_checker.sv
verif/increase_run_window_checker_unit_tb.sv
